// ----- rtl/rsc_pkg.sv -----
// Shared types, codes and helpers of the RPN stack calculator.
package rsc_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DIV_W       = DATA_W + FRAC_BITS;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] OPC_PUSH  = 4'd0;
   localparam logic [3:0] OPC_ADD   = 4'd1;
   localparam logic [3:0] OPC_SUB   = 4'd2;
   localparam logic [3:0] OPC_MUL   = 4'd3;
   localparam logic [3:0] OPC_DIV   = 4'd4;
   localparam logic [3:0] OPC_MOD   = 4'd5;
   localparam logic [3:0] OPC_POP   = 4'd6;
   localparam logic [3:0] OPC_PEEK  = 4'd7;
   localparam logic [3:0] OPC_DUP   = 4'd8;
   localparam logic [3:0] OPC_SWAP  = 4'd9;
   localparam logic [3:0] OPC_CLEAR = 4'd10;
   localparam logic [3:0] OPC_NOP   = 4'd15;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_UNDER  = 3'd1;
   localparam logic [2:0] ST_FULL   = 3'd2;
   localparam logic [2:0] ST_ZDIV   = 3'd3;
   localparam logic [2:0] ST_ZMOD   = 3'd4;
   localparam logic [2:0] ST_NONINT = 3'd5;

   localparam logic [DATA_W-1:0] FRAC_MASK = DATA_W'((64'd1 << FRAC_BITS) - 64'd1);

   typedef struct packed {
      logic [3:0]        kind;
      logic [DATA_W-1:0] operand;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   // saturate a magnitude with sign to a signed 32-bit word
   function automatic logic [DATA_W-1:0] sat32(input logic [63:0] m, input logic neg);
      logic [DATA_W-1:0] r;
      if (neg) begin
         if (m > 64'h8000_0000) r = 32'h8000_0000;
         else r = -m[31:0];
      end else begin
         if (m > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
         else r = m[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/rsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rsc_front.sv -----
// Command intake: decode of the opcode and a short queue toward the executer.
module rsc_front import rsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [3:0]        req_opcode,
   input  logic [DATA_W-1:0] req_operand,
   output qhead_type         head,
   input  logic              pop
);

   localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QF_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QP_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QF_W-1:0]   fill_ff, fill_in;
   logic              accept;
   logic              do_pop;
   cmd_type           cmd;

   always_comb begin
      cmd.operand = req_operand;
      unique case (req_opcode) inside
         OPC_PUSH, OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_MOD,
         OPC_POP, OPC_PEEK, OPC_DUP, OPC_SWAP, OPC_CLEAR: cmd.kind = req_opcode;
         default: cmd.kind = OPC_NOP;
      endcase
   end

   assign busy   = (fill_ff == QF_W'(QUEUE_DEPTH));
   assign accept = start && !busy;
   assign do_pop = pop && (fill_ff != '0);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (do_pop) rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (accept) wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      fill_in = fill_ff + QF_W'(accept) - QF_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) q_ff[wr_ptr_ff] <= cmd;
   end

   assign head.valid = (fill_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

endmodule

// ----- rtl/rsc_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module rsc_div import rsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient,
   output logic [DATA_W-1:0] remainder
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  dq_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] dsr_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              ge;

   assign trial = {rem_ff, dq_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= STEP_W'(DIV_W);
         end else if (run_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         dq_ff  <= {dq_ff[DIV_W-2:0], ge};
         rem_ff <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/rsc_back.sv -----
// Command executer: stack sequencer, multiplier and result register.
module rsc_back import rsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  qhead_type         head,
   output logic              pop,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [DATA_W-1:0] ram_wr_data,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [DATA_W-1:0] ram_rd_data,
   output logic              rsp_strobe,
   output logic [DATA_W-1:0] rsp_value,
   output logic              rsp_value_valid,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_depth
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD1   = 4'd1;
   localparam logic [3:0] S_RD2   = 4'd2;
   localparam logic [3:0] S_RD3   = 4'd3;
   localparam logic [3:0] S_EXEC  = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_MULW  = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_DIVW  = 4'd8;
   localparam logic [3:0] S_SWAP2 = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [3:0]        kind_ff;
   logic [DATA_W-1:0] operand_ff;
   logic [DATA_W-1:0] a_ff, b_ff;
   logic [DATA_W-1:0] mag_a_ff, mag_b_ff;
   logic              neg_ff;
   logic [63:0]       prod_ff;
   logic              strobe_ff;
   logic [DATA_W-1:0] value_ff;
   logic              vvalid_ff;
   logic [2:0]        status_ff;
   logic [7:0]        depth_ff;

   logic              fin;
   logic [DATA_W-1:0] res_value;
   logic              res_valid;
   logic [2:0]        res_status;
   logic              have_a, have_b, full;
   logic [CNT_W-1:0]  base;
   logic [2:0]        st_two;
   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_dividend;
   logic [DIV_W-1:0]  div_quo;
   logic [DATA_W-1:0] div_rem;

   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] x,
                                                 input logic [DATA_W-1:0] y,
                                                 input logic sub);
      logic [DATA_W:0] s;
      logic [DATA_W-1:0] r;
      if (sub) s = {x[DATA_W-1], x} - {y[DATA_W-1], y};
      else s = {x[DATA_W-1], x} + {y[DATA_W-1], y};
      if (s[DATA_W] != s[DATA_W-1]) r = s[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else r = s[DATA_W-1:0];
      return r;
   endfunction

   assign have_b = (cnt_ff != '0);
   assign have_a = (cnt_ff > CNT_W'(1));
   assign full   = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign base   = cnt_ff - (have_a ? CNT_W'(2) : (have_b ? CNT_W'(1) : CNT_W'(0)));
   assign st_two = have_a ? ST_OK : ST_UNDER;

   assign div_dividend = (kind_ff == OPC_DIV) ? (DIV_W'(mag_a_ff) << FRAC_BITS)
                                              : DIV_W'(mag_a_ff);

   rsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (mag_b_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pop         = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ADDR_W'(cnt_ff - CNT_W'(1));
      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_W'(base);
      ram_wr_data = operand_ff;
      div_start   = 1'b0;
      fin         = 1'b0;
      res_value   = '0;
      res_valid   = 1'b0;
      res_status  = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            ram_rd_en = 1'b1;
            state_in  = S_RD2;
         end
         S_RD2: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ADDR_W'(cnt_ff - CNT_W'(2));
            state_in    = S_RD3;
         end
         S_RD3: state_in = S_EXEC;
         S_EXEC: begin
            case (kind_ff)
               OPC_PUSH: begin
                  fin = 1'b1;
                  if (full) res_status = ST_FULL;
                  else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = ADDR_W'(cnt_ff);
                     cnt_in      = cnt_ff + CNT_W'(1);
                  end
               end
               OPC_ADD, OPC_SUB: begin
                  fin         = 1'b1;
                  ram_wr_en   = 1'b1;
                  ram_wr_data = sat_add(a_ff, b_ff, kind_ff == OPC_SUB);
                  cnt_in      = base + CNT_W'(1);
                  res_status  = st_two;
               end
               OPC_MUL: state_in = S_MUL;
               OPC_DIV: begin
                  if (b_ff == '0) begin
                     fin        = 1'b1;
                     cnt_in     = cnt_ff - CNT_W'(have_b);
                     res_status = have_b ? ST_ZDIV : ST_UNDER;
                  end else state_in = S_DIV;
               end
               OPC_MOD: begin
                  if (b_ff == '0) begin
                     fin        = 1'b1;
                     cnt_in     = base;
                     res_status = have_a ? ST_ZMOD : ST_UNDER;
                  end else if (((a_ff & FRAC_MASK) != '0) || ((b_ff & FRAC_MASK) != '0)) begin
                     fin        = 1'b1;
                     cnt_in     = base;
                     res_status = have_a ? ST_NONINT : ST_UNDER;
                  end else state_in = S_DIV;
               end
               OPC_POP: begin
                  fin        = 1'b1;
                  res_value  = b_ff;
                  res_valid  = have_b;
                  res_status = have_b ? ST_OK : ST_UNDER;
                  cnt_in     = cnt_ff - CNT_W'(have_b);
               end
               OPC_PEEK: begin
                  fin        = 1'b1;
                  res_value  = b_ff;
                  res_valid  = have_b;
                  res_status = have_b ? ST_OK : ST_UNDER;
               end
               OPC_DUP: begin
                  fin = 1'b1;
                  if (!have_b) res_status = ST_UNDER;
                  else if (full) res_status = ST_FULL;
                  else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = ADDR_W'(cnt_ff);
                     ram_wr_data = b_ff;
                     cnt_in      = cnt_ff + CNT_W'(1);
                  end
               end
               OPC_SWAP: begin
                  if (!have_a) begin
                     fin        = 1'b1;
                     res_status = ST_UNDER;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = ADDR_W'(cnt_ff - CNT_W'(1));
                     ram_wr_data = a_ff;
                     state_in    = S_SWAP2;
                  end
               end
               OPC_CLEAR: begin
                  fin    = 1'b1;
                  cnt_in = '0;
               end
               default: fin = 1'b1;
            endcase
         end
         S_MUL: state_in = S_MULW;
         S_MULW: begin
            fin         = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_data = sat32(prod_ff >> FRAC_BITS, neg_ff);
            cnt_in      = base + CNT_W'(1);
            res_status  = st_two;
         end
         S_DIV: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               fin        = 1'b1;
               ram_wr_en  = 1'b1;
               cnt_in     = base + CNT_W'(1);
               res_status = st_two;
               if (kind_ff == OPC_DIV) ram_wr_data = sat32(64'(div_quo), neg_ff);
               else ram_wr_data = a_ff[DATA_W-1] ? -div_rem : div_rem;
            end
         end
         S_SWAP2: begin
            fin         = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(cnt_ff - CNT_W'(2));
            ram_wr_data = b_ff;
         end
         default: state_in = S_IDLE;
      endcase
      if (fin) state_in = S_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
         value_ff  <= '0;
         vvalid_ff <= 1'b0;
         status_ff <= ST_OK;
         depth_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= fin;
         if (fin) begin
            value_ff  <= res_value;
            vvalid_ff <= res_valid;
            status_ff <= res_status;
            depth_ff  <= 8'(cnt_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff    <= head.cmd.kind;
         operand_ff <= head.cmd.operand;
      end
      // entries above the count are never taken as operands
      if (state_ff == S_RD2) b_ff <= have_b ? ram_rd_data : '0;
      if (state_ff == S_RD3) a_ff <= have_a ? ram_rd_data : '0;
      if (state_ff == S_EXEC) begin
         mag_a_ff <= a_ff[DATA_W-1] ? -a_ff : a_ff;
         mag_b_ff <= b_ff[DATA_W-1] ? -b_ff : b_ff;
         neg_ff   <= a_ff[DATA_W-1] ^ b_ff[DATA_W-1];
      end
      if (state_ff == S_MUL) prod_ff <= 64'(mag_a_ff) * 64'(mag_b_ff);
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_value       = value_ff;
   assign rsp_value_valid = vvalid_ff;
   assign rsp_status      = status_ff;
   assign rsp_depth       = depth_ff;

endmodule

// ----- rtl/rpn_stack_calculator.sv -----
// RPN stack calculator top level: command queue, executer and stack memory.
// Each command gets one result, shown on the rsp_ ports for one cycle under
// rsp_strobe; the receiver cannot stall it. busy rises when the two-entry
// command queue is full. A command leaves the queue, then makes two stack
// reads from the 1R1W stack RAM, then executes; swap adds a second write,
// multiply a product state and a write state, and divide or modulus with a
// usable divisor wait for the radix-2 divider that produces one of 48 quotient bits per cycle.
module rpn_stack_calculator import rsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [3:0]        req_opcode,
   input  logic [DATA_W-1:0] req_operand,
   output logic              rsp_strobe,
   output logic [DATA_W-1:0] rsp_value,
   output logic              rsp_value_valid,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_depth
);

   qhead_type         head;
   logic              pop;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   rsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req_opcode),
      .req_operand (req_operand),
      .head        (head),
      .pop         (pop)
   );

   rsc_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rsc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .ram_wr_en       (wr_en),
      .ram_wr_addr     (wr_addr),
      .ram_wr_data     (wr_data),
      .ram_rd_en       (rd_en),
      .ram_rd_addr     (rd_addr),
      .ram_rd_data     (rd_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_value       (rsp_value),
      .rsp_value_valid (rsp_value_valid),
      .rsp_status      (rsp_status),
      .rsp_depth       (rsp_depth)
   );

endmodule

// ----- rtl/rsc_checker.sv -----
// Port-level checks of the RPN stack calculator, bound to the top level.
module rsc_checker import rsc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_strobe,
   input logic [DATA_W-1:0] rsp_value,
   input logic              rsp_value_valid,
   input logic [2:0]        rsp_status,
   input logic [7:0]        rsp_depth
);

   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_value_valid |-> rsp_status == ST_OK)
      else $error("shown value with error status");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_value_valid |-> rsp_value == '0)
      else $error("value not zero when nothing is shown");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_depth <= 8'(STACK_DEPTH))
      else $error("depth beyond stack size");

   a_full_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_FULL |-> rsp_depth == 8'(STACK_DEPTH))
      else $error("full status on a stack that is not full");

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

endmodule

bind rpn_stack_calculator rsc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_strobe      (rsp_strobe),
   .rsp_value       (rsp_value),
   .rsp_value_valid (rsp_value_valid),
   .rsp_status      (rsp_status),
   .rsp_depth       (rsp_depth)
);
